### sv/ats_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants for the alias table sampler.
// ----------------------------------------------------------------------------
package ats_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int PROB_W = SUM_W + 1;
    localparam int NUM_W  = PROB_W + FRAC_BITS;
    localparam int T_W    = 32 + CNT_W;
    localparam int K_W    = $clog2(NUM_W);

    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_ENTRIES);
    localparam logic [PROB_W-1:0] PROB_ONE   = PROB_W'(1) << FRAC_BITS;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic capture;
        logic append;
        logic emit_load;
        logic emit_zero;
        logic bld_init;
        logic rd_weight;
        logic mul;
        logic div_step;
        logic scan_wr;
        logic pair_pop;
        logic pair_rd;
        logic pair_upd;
        logic lo_pop;
        logic lo_fill;
        logic hi_pop;
        logic hi_fill;
        logic finish;
        logic draw_mul;
        logic draw_rd;
        logic draw_emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic sum_zero;
        logic div_last;
        logic scan_last;
        logic lo_nz;
        logic hi_nz;
        logic no_table;
    } sts_t;

endpackage
`default_nettype wire

### sv/ats_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer for load, table build and draw requests.
// ----------------------------------------------------------------------------
module ats_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          mode,
    input  wire ats_pkg::sts_t sts,
    output ats_pkg::cmd_t      cmd,
    output logic               busy
);
    import ats_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_CHK      = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_MUL = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_SCAN_WR  = 4'd6;
    localparam logic [3:0] S_PAIR_CHK = 4'd7;
    localparam logic [3:0] S_PAIR_POP = 4'd8;
    localparam logic [3:0] S_PAIR_RD  = 4'd9;
    localparam logic [3:0] S_PAIR_UPD = 4'd10;
    localparam logic [3:0] S_LO_FILL  = 4'd11;
    localparam logic [3:0] S_HI_FILL  = 4'd12;
    localparam logic [3:0] S_DRAW_MUL = 4'd13;
    localparam logic [3:0] S_DRAW_RD  = 4'd14;
    localparam logic [3:0] S_DRAW_OUT = 4'd15;

    logic [3:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mode ? S_DRAW_MUL : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.append = 1'b1;
                if (sts.last)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CHK:
            begin
                if (sts.sum_zero)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.bld_init = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_weight = 1'b1;
                state_next    = S_SCAN_MUL;
            end
            S_SCAN_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SCAN_WR;
                end
            end
            S_SCAN_WR:
            begin
                cmd.scan_wr = 1'b1;
                state_next  = sts.scan_last ? S_PAIR_CHK : S_SCAN_RD;
            end
            S_PAIR_CHK:
            begin
                if (sts.lo_nz && sts.hi_nz)
                begin
                    state_next = S_PAIR_POP;
                end
                else if (sts.lo_nz)
                begin
                    cmd.lo_pop = 1'b1;
                    state_next = S_LO_FILL;
                end
                else if (sts.hi_nz)
                begin
                    cmd.hi_pop = 1'b1;
                    state_next = S_HI_FILL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PAIR_POP:
            begin
                cmd.pair_pop = 1'b1;
                state_next   = S_PAIR_RD;
            end
            S_PAIR_RD:
            begin
                cmd.pair_rd = 1'b1;
                state_next  = S_PAIR_UPD;
            end
            S_PAIR_UPD:
            begin
                cmd.pair_upd = 1'b1;
                state_next   = S_PAIR_CHK;
            end
            S_LO_FILL:
            begin
                cmd.lo_fill = 1'b1;
                state_next  = S_PAIR_CHK;
            end
            S_HI_FILL:
            begin
                cmd.hi_fill = 1'b1;
                state_next  = S_PAIR_CHK;
            end
            S_DRAW_MUL:
            begin
                cmd.draw_mul = 1'b1;
                state_next   = sts.no_table ? S_IDLE : S_DRAW_RD;
            end
            S_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = S_DRAW_OUT;
            end
            S_DRAW_OUT:
            begin
                cmd.draw_emit = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_pair_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR_POP) |-> (sts.lo_nz && sts.hi_nz))
        else $error("pair pop with an empty stack");

    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == S_IDLE))
        else $error("request captured while busy");

    a_draw_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_RD) |=> (state_reg == S_DRAW_OUT))
        else $error("draw sequence broken");

endmodule
`default_nettype wire

### sv/ats_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ats_dpath
// Entry stores, build stacks, divider and draw arithmetic.
// ----------------------------------------------------------------------------
module ats_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ats_pkg::cmd_t cmd,
    input  wire logic [15:0]   weight,
    input  wire logic          load_last,
    input  wire logic [31:0]   random_word,
    input  wire logic          draw_last,
    output ats_pkg::sts_t      sts,
    output logic               done,
    output logic [9:0]         sample_index,
    output logic [1:0]         status,
    output logic               batch_end
);
    import ats_pkg::*;

    logic [WEIGHT_BITS-1:0] wmem [MAX_ENTRIES];
    logic [PROB_W-1:0]      pmem [MAX_ENTRIES];
    logic [IDX_W-1:0]       amem [MAX_ENTRIES];
    logic [IDX_W-1:0]       lmem [MAX_ENTRIES];
    logic [IDX_W-1:0]       hmem [MAX_ENTRIES];

    logic [CNT_W-1:0]       cnt_reg, tsize_reg, lo_reg, hi_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   drop_reg, last_reg, dlast_reg;
    logic [WEIGHT_BITS-1:0] win_reg;
    logic [31:0]            rand_reg;
    logic [IDX_W-1:0]       i_reg, idx_reg, l_reg, h_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [PROB_W-1:0]      rem_reg, quo_reg;
    logic [K_W-1:0]         k_reg;
    logic [T_W-1:0]         t_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic                   done_reg;
    logic [9:0]             sample_reg;
    logic [1:0]             status_reg;
    logic                   bend_reg;

    logic [WEIGHT_BITS-1:0] w_rd;
    logic [PROB_W-1:0]      pa_rd, pb_rd;
    logic [IDX_W-1:0]       a_rd, l_rd, h_rd;

    logic                   full;
    logic [PROB_W-1:0]      prod, rem_sh, np;
    logic                   ge;
    logic [T_W-1:0]         t_mul;

    logic                   p_we;
    logic [IDX_W-1:0]       p_wa;
    logic [PROB_W-1:0]      p_wd;
    logic                   a_we;
    logic [IDX_W-1:0]       a_wa, a_wd;
    logic [IDX_W-1:0]       p_ra;
    logic                   push_lo, push_hi;
    logic [IDX_W-1:0]       push_v;

    assign full   = (cnt_reg == FULL_COUNT);
    assign prod   = PROB_W'(w_rd) * PROB_W'(cnt_reg);
    assign rem_sh = {rem_reg[PROB_W-2:0], num_reg[NUM_W-1]};
    assign ge     = (rem_sh >= PROB_W'(sum_reg));
    assign np     = pb_rd - PROB_ONE + pa_rd;
    assign t_mul  = T_W'(rand_reg) * T_W'(tsize_reg);

    assign sts.last      = last_reg;
    assign sts.sum_zero  = (sum_reg == '0);
    assign sts.div_last  = (k_reg == K_W'(NUM_W - 1));
    assign sts.scan_last = ({1'b0, i_reg} == (cnt_reg - CNT_W'(1)));
    assign sts.lo_nz     = (lo_reg != '0);
    assign sts.hi_nz     = (hi_reg != '0);
    assign sts.no_table  = (tsize_reg == '0);

    always_comb
    begin
        p_we    = 1'b0;
        p_wa    = i_reg;
        p_wd    = quo_reg;
        a_we    = 1'b0;
        a_wa    = i_reg;
        a_wd    = i_reg;
        push_lo = 1'b0;
        push_hi = 1'b0;
        push_v  = i_reg;
        p_ra    = t_reg[32 +: IDX_W];
        if (cmd.pair_rd)
        begin
            p_ra = l_rd;
        end
        if (cmd.scan_wr)
        begin
            p_we    = 1'b1;
            a_we    = 1'b1;
            push_lo = (quo_reg < PROB_ONE);
            push_hi = (quo_reg > PROB_ONE);
        end
        if (cmd.pair_upd)
        begin
            p_we    = 1'b1;
            p_wa    = h_reg;
            p_wd    = np;
            a_we    = 1'b1;
            a_wa    = l_reg;
            a_wd    = h_reg;
            push_v  = h_reg;
            push_lo = (np < PROB_ONE);
            push_hi = (np > PROB_ONE);
        end
        if (cmd.lo_fill)
        begin
            p_we = 1'b1;
            p_wa = l_rd;
            p_wd = PROB_ONE;
        end
        if (cmd.hi_fill)
        begin
            p_we = 1'b1;
            p_wa = h_rd;
            p_wd = PROB_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            wmem[cnt_reg[IDX_W-1:0]] <= win_reg;
        end
        if (cmd.rd_weight)
        begin
            w_rd <= wmem[i_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_wa] <= p_wd;
        end
        if (cmd.pair_rd || cmd.draw_rd)
        begin
            pa_rd <= pmem[p_ra];
            pb_rd <= pmem[h_rd];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[a_wa] <= a_wd;
        end
        if (cmd.draw_rd)
        begin
            a_rd <= amem[t_reg[32 +: IDX_W]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_lo)
        begin
            lmem[lo_reg[IDX_W-1:0]] <= push_v;
        end
        if (cmd.pair_pop || cmd.lo_pop)
        begin
            l_rd <= lmem[lo_reg[IDX_W-1:0] - IDX_W'(1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_hi)
        begin
            hmem[hi_reg[IDX_W-1:0]] <= push_v;
        end
        if (cmd.pair_pop || cmd.hi_pop)
        begin
            h_rd <= hmem[hi_reg[IDX_W-1:0] - IDX_W'(1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            win_reg   <= weight[WEIGHT_BITS-1:0];
            rand_reg  <= random_word;
            dlast_reg <= draw_last;
        end
        if (cmd.append)
        begin
            drop_reg <= full;
        end
        if (cmd.mul)
        begin
            num_reg <= {prod, FRAC_BITS'(0)};
            rem_reg <= '0;
            quo_reg <= '0;
            k_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? (rem_sh - PROB_W'(sum_reg)) : rem_sh;
            quo_reg <= {quo_reg[PROB_W-2:0], ge};
            k_reg   <= k_reg + K_W'(1);
        end
        if (cmd.pair_rd)
        begin
            l_reg <= l_rd;
            h_reg <= h_rd;
        end
        if (cmd.draw_mul)
        begin
            t_reg <= t_mul;
        end
        if (cmd.draw_rd)
        begin
            idx_reg  <= t_reg[32 +: IDX_W];
            frac_reg <= t_reg[32-FRAC_BITS +: FRAC_BITS];
        end
        sample_reg <= '0;
        bend_reg   <= 1'b0;
        status_reg <= ST_OK;
        if (cmd.emit_load || cmd.finish)
        begin
            status_reg <= (cmd.emit_load ? full : drop_reg) ? ST_FULL : ST_OK;
        end
        if (cmd.emit_zero)
        begin
            status_reg <= ST_ZERO;
        end
        if (cmd.draw_mul)
        begin
            bend_reg   <= dlast_reg;
            status_reg <= ST_EMPTY;
        end
        if (cmd.draw_emit)
        begin
            bend_reg   <= dlast_reg;
            sample_reg <= 10'((pa_rd <= PROB_W'(frac_reg)) ? a_rd : idx_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            tsize_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit_load || cmd.emit_zero || cmd.finish || cmd.draw_emit
                        || (cmd.draw_mul && sts.no_table);
            if (cmd.capture)
            begin
                last_reg <= load_last;
            end
            if (cmd.append && !full)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                sum_reg <= sum_reg + SUM_W'(win_reg);
            end
            if (cmd.emit_zero || cmd.finish)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
            end
            if (cmd.emit_zero)
            begin
                tsize_reg <= '0;
            end
            if (cmd.finish)
            begin
                tsize_reg <= cnt_reg;
            end
            if (cmd.bld_init)
            begin
                i_reg  <= '0;
                lo_reg <= '0;
                hi_reg <= '0;
            end
            if (cmd.scan_wr)
            begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (cmd.pair_pop || cmd.lo_pop)
            begin
                lo_reg <= lo_reg - CNT_W'(1);
            end
            if (cmd.pair_pop || cmd.hi_pop)
            begin
                hi_reg <= hi_reg - CNT_W'(1);
            end
            if (push_lo)
            begin
                lo_reg <= lo_reg + CNT_W'(1);
            end
            if (push_hi)
            begin
                hi_reg <= hi_reg + CNT_W'(1);
            end
        end
    end

    assign done         = done_reg;
    assign sample_index = sample_reg;
    assign status       = status_reg;
    assign batch_end    = bend_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (12'(lo_reg) + 12'(hi_reg)) <= 12'(MAX_ENTRIES))
        else $error("stack depth exceeds entry count");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_OK && bend_reg) |->
        (CNT_W'(sample_reg) < tsize_reg))
        else $error("sample index outside table");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_COUNT)
        else $error("entry count overflow");

endmodule
`default_nettype wire

### sv/alias_table_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alias_table_sampler
// Weighted discrete sampler with alias table build and single-read draws.
// ----------------------------------------------------------------------------
// Every request returns one result on done, one cycle wide; the receiver
// cannot stall it, so take it when it comes. A draw multiplies, reads the
// table and compares; with no table it ends after the multiply. The final
// load builds the table unless the weight sum is zero: for each entry a
// one-bit-per-cycle divider scales the weight to a probability, then the
// stacks are paired and leftovers filled; busy stays high for the whole build.
// ----------------------------------------------------------------------------
module alias_table_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [15:0] weight,
    input  wire logic        load_last,
    input  wire logic [31:0] random_word,
    input  wire logic        draw_last,
    output logic             done,
    output logic [9:0]       sample_index,
    output logic [1:0]       status,
    output logic             batch_end
);
    import ats_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ats_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ats_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .weight       (weight),
        .load_last    (load_last),
        .random_word  (random_word),
        .draw_last    (draw_last),
        .sts          (sts),
        .done         (done),
        .sample_index (sample_index),
        .status       (status),
        .batch_end    (batch_end)
    );

endmodule
`default_nettype wire
